FILE: design/ckeu_pkg.sv
// Shared types, constants and helpers for the calculator keystroke engine.
// No dependencies; imported by every module of the block.
package ckeu_pkg;

    localparam int WORD_BITS  = 16;
    localparam int VALUE_BITS = 16;
    localparam int CHAR_BITS  = 8;
    localparam int CNT_BITS   = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CHAR_BITS-1:0]  char_t;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_EQUAL = 8'h3D;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CMD_DIGIT = 2'd0,
        CMD_OP    = 2'd1,
        CMD_EQ    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        op_t       op;
        char_t     ch;
    } cmd_t;

    typedef struct packed {
        logic  start;
        logic  is_div;
        word_t a;
        word_t b;
    } arith_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } arith_rsp_t;

    localparam logic KIND_ECHO   = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    function automatic value_t to_value(input word_t w);
        logic [WORD_BITS+VALUE_BITS-1:0] ext;
        begin
            ext = {{VALUE_BITS{1'b0}}, w};
            return ext[VALUE_BITS-1:0];
        end
    endfunction

endpackage

FILE: design/ckeu_front.sv
// Input side: takes characters, classifies them and holds commands in a two-entry queue.
// Depends on ckeu_pkg.
module ckeu_front
    import ckeu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  char_t s_key_char,
    output logic  q_valid,
    output cmd_t  q_cmd,
    input  logic  q_pop
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cls;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb begin
        cls.ch   = s_key_char;
        cls.op   = OP_NONE;
        cls.kind = CMD_EQ;
        keep     = 1'b1;
        if (s_key_char >= CH_ZERO && s_key_char <= CH_NINE) begin
            cls.kind = CMD_DIGIT;
        end else begin
            unique case (s_key_char)
                CH_PLUS:  begin cls.kind = CMD_OP; cls.op = OP_ADD; end
                CH_MINUS: begin cls.kind = CMD_OP; cls.op = OP_SUB; end
                CH_STAR:  begin cls.kind = CMD_OP; cls.op = OP_MUL; end
                CH_SLASH: begin cls.kind = CMD_OP; cls.op = OP_DIV; end
                CH_EQUAL: cls.kind = CMD_EQ;
                default:  keep = 1'b0;
            endcase
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && keep;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: design/ckeu_arith.sv
// Iterative unit: shift-add multiply and restoring divide, one bit per cycle.
// Depends on ckeu_pkg.
module ckeu_arith
    import ckeu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                div_reg, div_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    word_t               x_reg, x_next;
    word_t               y_reg, y_next;
    word_t               z_reg, z_next;
    logic                done_reg, done_next;
    word_t               res_reg, res_next;
    logic                zero_div_reg, zero_div_next;
    logic [WORD_BITS:0]  trial;
    logic                fits;

    assign trial = {z_reg, x_reg[WORD_BITS-1]};
    assign fits  = (trial >= {1'b0, y_reg});

    always_comb begin
        busy_next     = busy_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        zero_div_next = zero_div_reg;
        if (req.start) begin
            busy_next     = 1'b1;
            div_next      = req.is_div;
            cnt_next      = CNT_BITS'(WORD_BITS - 1);
            x_next        = req.a;
            y_next        = req.b;
            z_next        = '0;
            zero_div_next = (req.b == '0);
        end else if (busy_reg) begin
            if (div_reg) begin
                if (fits) begin
                    z_next = WORD_BITS'(trial - {1'b0, y_reg});
                end else begin
                    z_next = trial[WORD_BITS-1:0];
                end
                x_next = {x_reg[WORD_BITS-2:0], fits};
            end else begin
                z_next = z_reg + (y_reg[0] ? x_reg : '0);
                x_next = {x_reg[WORD_BITS-2:0], 1'b0};
                y_next = {1'b0, y_reg[WORD_BITS-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (div_reg) begin
                    res_next = zero_div_reg ? x_reg : x_next;
                end else begin
                    res_next = z_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg      <= div_next;
        cnt_reg      <= cnt_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        res_reg      <= res_next;
        zero_div_reg <= zero_div_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

FILE: design/ckeu_back.sv
// Execution side: calculator state, command sequencer and registered result output.
// Depends on ckeu_pkg and drives the ckeu_arith request port.
module ckeu_back
    import ckeu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output arith_req_t areq,
    input  arith_rsp_t arsp,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output char_t      m_echo_char,
    output value_t     m_value,
    output logic       m_last
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_RES  = 4'b0100,
        ST_ECHO = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    word_t  entry_reg, entry_next;
    word_t  accum_reg, accum_next;
    op_t    pend_reg, pend_next;
    cmd_t   cmd_reg, cmd_next;
    word_t  res_reg, res_next;

    logic   m_valid_reg, m_valid_next;
    logic   kind_reg, kind_next;
    char_t  char_reg, char_next;
    value_t value_reg, value_next;
    logic   last_reg, last_next;

    logic   out_free;
    logic   out_load;
    word_t  digit_w;

    assign out_free = !m_valid_reg || m_ready;
    assign digit_w  = {{(WORD_BITS-4){1'b0}}, q_cmd.ch[3:0]};

    always_comb begin
        state_next = state_reg;
        entry_next = entry_reg;
        accum_next = accum_reg;
        pend_next  = pend_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        q_pop      = 1'b0;
        areq       = '{start: 1'b0, is_div: 1'b0, a: accum_reg, b: entry_reg};
        out_load   = 1'b0;
        kind_next  = kind_reg;
        char_next  = char_reg;
        value_next = value_reg;
        last_next  = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == CMD_DIGIT) begin
                        entry_next = (entry_reg << 3) + (entry_reg << 1) + digit_w;
                        out_load   = 1'b1;
                        kind_next  = KIND_ECHO;
                        char_next  = q_cmd.ch;
                        value_next = '0;
                        last_next  = 1'b1;
                    end else if (entry_reg == '0) begin
                        if (q_cmd.kind == CMD_OP) begin
                            pend_next = q_cmd.op;
                        end
                    end else if (pend_reg != OP_NONE) begin
                        cmd_next = q_cmd;
                        case (pend_reg)
                            OP_ADD: begin
                                res_next   = accum_reg + entry_reg;
                                state_next = ST_RES;
                            end
                            OP_SUB: begin
                                res_next   = accum_reg - entry_reg;
                                state_next = ST_RES;
                            end
                            OP_MUL: begin
                                areq.start = 1'b1;
                                state_next = ST_CALC;
                            end
                            OP_DIV: begin
                                areq.start  = 1'b1;
                                areq.is_div = 1'b1;
                                state_next  = ST_CALC;
                            end
                            default: begin
                                res_next   = accum_reg;
                                state_next = ST_RES;
                            end
                        endcase
                    end else if (q_cmd.kind == CMD_OP) begin
                        accum_next = entry_reg;
                        entry_next = '0;
                        pend_next  = q_cmd.op;
                        out_load   = 1'b1;
                        kind_next  = KIND_ECHO;
                        char_next  = q_cmd.ch;
                        value_next = '0;
                        last_next  = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                if (arsp.done) begin
                    res_next   = arsp.result;
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    kind_next  = KIND_RESULT;
                    char_next  = '0;
                    value_next = to_value(res_reg);
                    last_next  = (cmd_reg.kind != CMD_OP);
                    accum_next = res_reg;
                    entry_next = res_reg;
                    pend_next  = OP_NONE;
                    state_next = (cmd_reg.kind == CMD_OP) ? ST_ECHO : ST_IDLE;
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    kind_next  = KIND_ECHO;
                    char_next  = cmd_reg.ch;
                    value_next = '0;
                    last_next  = 1'b1;
                    accum_next = entry_reg;
                    entry_next = '0;
                    pend_next  = cmd_reg.op;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            entry_reg   <= '0;
            accum_reg   <= '0;
            pend_reg    <= OP_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            entry_reg   <= entry_next;
            accum_reg   <= accum_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        kind_reg  <= kind_next;
        char_reg  <= char_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_item_kind = kind_reg;
    assign m_echo_char = char_reg;
    assign m_value     = value_reg;
    assign m_last      = last_reg;

endmodule

FILE: design/calculator_keystroke_engine_unit.sv
// Calculator keystroke engine: one received character in, echo and result transactions out.
// The front classifies characters into a two-entry command queue, so input keeps being taken
// while the back works, until the queue is full. A digit echo, or that of an operator with no
// pending operation, is registered once its command reaches the head of the queue and the output
// is free; a chained result passes through ST_RES (after ST_CALC for a multiply or divide), and
// ST_ECHO then echoes a chaining operator. Ignored characters are consumed without output.
// Results wrap modulo 2^WORD_BITS. Depends on ckeu_pkg, ckeu_front, ckeu_arith and ckeu_back.
module calculator_keystroke_engine_unit
    import ckeu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  char_t  s_key_char,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_item_kind,
    output char_t  m_echo_char,
    output value_t m_value,
    output logic   m_last
);

    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;
    arith_req_t areq;
    arith_rsp_t arsp;

    ckeu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_key_char (s_key_char),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    ckeu_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (areq),
        .rsp     (arsp)
    );

    ckeu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .areq        (areq),
        .arsp        (arsp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item_kind (m_item_kind),
        .m_echo_char (m_echo_char),
        .m_value     (m_value),
        .m_last      (m_last)
    );

endmodule
